// ===== sv/hybrid_huffman_fixed_bit_packer_core_macros.svh =====
// Assertion macros shared by the bit packer modules.
`ifndef HYBRID_HUFFMAN_FIXED_BIT_PACKER_CORE_MACROS_SVH
`define HYBRID_HUFFMAN_FIXED_BIT_PACKER_CORE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define HHFBP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define HHFBP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HHFBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hhfbp_pkg.sv =====
// Package with the types, constants and the bit packing function of the packer.
`default_nettype none
package hhfbp_pkg;

   localparam int SYMBOL_BITS     = 16;
   localparam int MAX_CODE_LEN    = 32;
   localparam int TableAddrWidth  = SYMBOL_BITS;
   localparam int CodeWidth       = 32;
   localparam int LenWidth        = 6;
   localparam int SymbolWidth     = 16;
   localparam int ByteWidth       = 8;
   localparam int PendWidth       = 7;
   localparam int PendCountWidth  = 3;
   localparam int MaxBytes        = 4;
   localparam int ByteCountWidth  = 3;
   localparam int AccWidth        = CodeWidth + PendWidth;
   localparam int EntryWidth      = 32;
   localparam int TotalWidth      = 40;
   localparam int CfgWidth        = 6;
   localparam int TableDataWidth  = CodeWidth + LenWidth;
   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);
   localparam int ResultIdxWidth  = 3;

   localparam logic [CfgWidth-1:0] FallbackReset = CfgWidth'(16);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_CLOSE  = 2'd2,
      OP_FLUSH  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_HI     = 2'd0,
      KIND_LO     = 2'd1,
      KIND_ENTRY  = 2'd2,
      KIND_TOTALS = 2'd3
   } kind_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [SymbolWidth-1:0] symbol;
      logic [CodeWidth-1:0]   code;
      logic [LenWidth-1:0]    code_len;
      logic                   end_of_entry;
   } req_item_type;

   typedef struct packed {
      kind_type                kind;
      logic [ByteWidth-1:0]    out_byte;
      logic [EntryWidth-1:0]   entry_bits;
      logic [TotalWidth-1:0]   total_bits_hi;
      logic [TotalWidth-1:0]   total_bits_lo;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code;
      logic [LenWidth-1:0]  len;
   } table_entry_type;

   typedef struct packed {
      logic [ByteCountWidth-1:0]      nbytes;
      logic [MaxBytes-1:0]            byte_is_lo;
      logic [MaxBytes*ByteWidth-1:0]  bytes;
      logic                           tail_valid;
      logic                           tail_totals;
      logic [EntryWidth-1:0]          entry_bits;
      logic [TotalWidth-1:0]          total_hi;
      logic [TotalWidth-1:0]          total_lo;
   } bundle_type;

   typedef struct packed {
      logic [MaxBytes*ByteWidth-1:0] bytes;
      logic [ByteCountWidth-1:0]     nbytes;
      logic [PendWidth-1:0]          rem_bits;
      logic [PendCountWidth-1:0]     rem_cnt;
   } pack_result_type;

   // Appends len bits of value, most significant first, to the pending bits and
   // returns the completed bytes together with the new pending bits.
   function automatic pack_result_type pack_bits(
      input logic [CodeWidth-1:0]      value,
      input logic [LenWidth-1:0]       len,
      input logic [PendWidth-1:0]      pend_bits,
      input logic [PendCountWidth-1:0] pend_cnt
   );
      logic [CodeWidth-1:0] aligned;
      logic [CodeWidth-1:0] rev;
      logic [AccWidth-1:0]  acc;
      logic [LenWidth-1:0]  total;
      pack_result_type      res;
      aligned = value << (LenWidth'(CodeWidth) - len);
      for (int i = 0; i < CodeWidth; i++) begin
         rev[i] = aligned[CodeWidth-1-i];
      end
      acc          = (AccWidth'(rev) << pend_cnt) | AccWidth'(pend_bits);
      total        = LenWidth'(pend_cnt) + len;
      res.bytes    = acc[MaxBytes*ByteWidth-1:0];
      res.nbytes   = total[LenWidth-1:3];
      res.rem_cnt  = total[2:0];
      res.rem_bits = PendWidth'(acc >> {total[LenWidth-1:3], 3'b000});
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== sv/hhfbp_table_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM for the code table.
`default_nettype none
module hhfbp_table_ram #(
   parameter int AddrWidth = 16,
   parameter int DataWidth = 38
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [DataWidth-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [DataWidth-1:0] rd_data
);

   logic [DataWidth-1:0] mem_ff [2**AddrWidth];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/hhfbp_packer.sv =====
// Second stage: applies the table lookup, packs stream bits and keeps the counters.
`default_nettype none
`include "hybrid_huffman_fixed_bit_packer_core_macros.svh"
module hhfbp_packer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire hhfbp_pkg::req_item_type          in_item,
   input  wire hhfbp_pkg::table_entry_type       rd_entry,
   input  wire logic [hhfbp_pkg::CfgWidth-1:0]   fallback_bits,
   output logic                                  busy,
   output logic                                  push,
   output hhfbp_pkg::bundle_type                 bundle
);
   import hhfbp_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   req_item_type               s1_item_ff;
   logic [PendWidth-1:0]       hi_bits_ff, hi_bits_in, lo_bits_ff, lo_bits_in;
   logic [PendCountWidth-1:0]  hi_cnt_ff, hi_cnt_in, lo_cnt_ff, lo_cnt_in;
   logic [EntryWidth-1:0]      entry_ff, entry_in;
   logic [TotalWidth-1:0]      hi_total_ff, hi_total_in, lo_total_ff, lo_total_in;

   logic                       coded;
   logic [LenWidth-1:0]        fb_width;
   pack_result_type            pk;
   logic [EntryWidth:0]        entry_sum;
   logic [EntryWidth-1:0]      entry_sat;
   logic [EntryWidth-1:0]      entry_new;
   logic [TotalWidth:0]        hi_sum, lo_sum;
   logic [TotalWidth-1:0]      hi_sat, lo_sat;
   logic                       hi_nz, lo_nz;

   assign s1_valid_in = in_valid;
   assign busy        = s1_valid_ff;

   always_comb begin
      coded    = (rd_entry.len != '0);
      fb_width = (fallback_bits > LenWidth'(CodeWidth)) ? LenWidth'(CodeWidth) : fallback_bits;
      pk = pack_bits(coded ? rd_entry.code : CodeWidth'(s1_item_ff.symbol),
                     coded ? rd_entry.len : fb_width,
                     coded ? hi_bits_ff : lo_bits_ff,
                     coded ? hi_cnt_ff : lo_cnt_ff);
      entry_sum = {1'b0, entry_ff} + (EntryWidth + 1)'(rd_entry.len);
      entry_sat = entry_sum[EntryWidth] ? '1 : entry_sum[EntryWidth-1:0];
      hi_sum    = {1'b0, hi_total_ff} + (TotalWidth + 1)'(rd_entry.len);
      hi_sat    = hi_sum[TotalWidth] ? '1 : hi_sum[TotalWidth-1:0];
      lo_sum    = {1'b0, lo_total_ff} + (TotalWidth + 1)'(fb_width);
      lo_sat    = lo_sum[TotalWidth] ? '1 : lo_sum[TotalWidth-1:0];
      hi_nz     = (hi_cnt_ff != '0);
      lo_nz     = (lo_cnt_ff != '0);
   end

   always_comb begin
      hi_bits_in  = hi_bits_ff;
      hi_cnt_in   = hi_cnt_ff;
      lo_bits_in  = lo_bits_ff;
      lo_cnt_in   = lo_cnt_ff;
      entry_in    = entry_ff;
      hi_total_in = hi_total_ff;
      lo_total_in = lo_total_ff;
      entry_new   = entry_ff;
      push        = 1'b0;
      bundle      = '0;
      if (s1_valid_ff) begin
         unique case (s1_item_ff.opcode)
            OP_LOAD: begin
            end
            OP_ENCODE: begin
               if (coded) begin
                  hi_bits_in  = pk.rem_bits;
                  hi_cnt_in   = pk.rem_cnt;
                  hi_total_in = hi_sat;
                  entry_new   = entry_sat;
               end else begin
                  lo_bits_in  = pk.rem_bits;
                  lo_cnt_in   = pk.rem_cnt;
                  lo_total_in = lo_sat;
               end
               bundle.nbytes     = pk.nbytes;
               bundle.byte_is_lo = coded ? '0 : '1;
               bundle.bytes      = pk.bytes;
               bundle.tail_valid = s1_item_ff.end_of_entry;
               bundle.entry_bits = entry_new;
               entry_in          = s1_item_ff.end_of_entry ? '0 : entry_new;
               push              = (pk.nbytes != '0) || s1_item_ff.end_of_entry;
            end
            OP_CLOSE: begin
               bundle.tail_valid = 1'b1;
               bundle.entry_bits = entry_ff;
               entry_in          = '0;
               push              = 1'b1;
            end
            OP_FLUSH: begin
               bundle.nbytes = ByteCountWidth'(hi_nz) + ByteCountWidth'(lo_nz);
               bundle.bytes[ByteWidth-1:0] = hi_nz ? ByteWidth'(hi_bits_ff)
                                                   : ByteWidth'(lo_bits_ff);
               bundle.bytes[2*ByteWidth-1:ByteWidth] = ByteWidth'(lo_bits_ff);
               bundle.byte_is_lo[0] = !hi_nz;
               bundle.byte_is_lo[1] = 1'b1;
               bundle.tail_valid    = 1'b1;
               bundle.tail_totals   = 1'b1;
               bundle.total_hi      = hi_total_ff;
               bundle.total_lo      = lo_total_ff;
               hi_bits_in  = '0;
               hi_cnt_in   = '0;
               lo_bits_in  = '0;
               lo_cnt_in   = '0;
               hi_total_in = '0;
               lo_total_in = '0;
               push        = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hi_bits_ff  <= '0;
         hi_cnt_ff   <= '0;
         lo_bits_ff  <= '0;
         lo_cnt_ff   <= '0;
         entry_ff    <= '0;
         hi_total_ff <= '0;
         lo_total_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         hi_bits_ff  <= hi_bits_in;
         hi_cnt_ff   <= hi_cnt_in;
         lo_bits_ff  <= lo_bits_in;
         lo_cnt_ff   <= lo_cnt_in;
         entry_ff    <= entry_in;
         hi_total_ff <= hi_total_in;
         lo_total_ff <= lo_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_item_ff <= in_item;
      end
   end

   `HHFBP_ASSERT_NEXT(a_flush_clears, s1_valid_ff && (s1_item_ff.opcode == OP_FLUSH), (hi_cnt_ff == '0) && (lo_cnt_ff == '0) && (hi_total_ff == '0) && (lo_total_ff == '0), "flush did not clear the stream state")

endmodule
`default_nettype wire

// ===== sv/hhfbp_result_queue.sv =====
// Result queue: holds per-item result bundles and sends them out one beat at a time.
`default_nettype none
`include "hybrid_huffman_fixed_bit_packer_core_macros.svh"
module hhfbp_result_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire hhfbp_pkg::bundle_type   bundle,
   input  wire logic                    in_flight,
   output logic                         credit_full,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output hhfbp_pkg::rsp_item_type      rsp_item
);
   import hhfbp_pkg::*;

   bundle_type                  queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0]  count_ff, count_in;
   logic [ResultIdxWidth-1:0]   idx_ff, idx_in;
   bundle_type                  head;
   logic [ResultIdxWidth-1:0]   nres;
   logic                        last;
   logic                        pop;
   logic [QueueCountWidth:0]    occupancy;

   always_comb begin
      head      = queue_ff[rd_ptr_ff];
      nres      = ResultIdxWidth'(head.nbytes) + ResultIdxWidth'(head.tail_valid);
      last      = (idx_ff == nres - ResultIdxWidth'(1));
      rsp_valid = (count_ff != '0);
      pop       = rsp_valid && !rsp_stall && last;
      occupancy = {1'b0, count_ff} + (QueueCountWidth + 1)'(in_flight);
      credit_full = (occupancy >= (QueueCountWidth + 1)'(QueueDepth));
   end

   always_comb begin
      rsp_item      = '0;
      rsp_item.last = last;
      if (idx_ff < ResultIdxWidth'(head.nbytes)) begin
         rsp_item.kind     = head.byte_is_lo[idx_ff[1:0]] ? KIND_LO : KIND_HI;
         rsp_item.out_byte = head.bytes[{idx_ff[1:0], 3'b000} +: ByteWidth];
      end else if (head.tail_totals) begin
         rsp_item.kind          = KIND_TOTALS;
         rsp_item.total_bits_hi = head.total_hi;
         rsp_item.total_bits_lo = head.total_lo;
      end else begin
         rsp_item.kind       = KIND_ENTRY;
         rsp_item.entry_bits = head.entry_bits;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      idx_in    = idx_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
      count_in = count_ff + QueueCountWidth'(push) - QueueCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= bundle;
      end
   end

   `HHFBP_ASSERT_IMPLY(a_no_overflow, push, (count_ff < QueueCountWidth'(QueueDepth)) || pop, "result queue overflow")
   `HHFBP_ASSERT_IMPLY(a_push_nonempty, push, (bundle.nbytes != '0) || bundle.tail_valid, "empty bundle pushed")
   `HHFBP_ASSERT_IMPLY(a_idx_in_range, rsp_valid, idx_ff < nres, "result index beyond bundle")

endmodule
`default_nettype wire

// ===== sv/hybrid_huffman_fixed_bit_packer_core.sv =====
// Top level of the Huffman / fixed-width bit packer with a 2^SYMBOL_BITS entry code table.
// Flow: an accepted item and its table read are registered, then the packer forms a bundle for the result queue.
// Throughput: one item per cycle while req_stall is low; results leave one beat per cycle while
// rsp_stall is low; an item with k results gives k beats; the four-entry queue throttles input.
// Reset: a clearing pass writes every table entry (2^SYMBOL_BITS = 65536 entries) with req_stall high.
`default_nettype none
module hybrid_huffman_fixed_bit_packer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire hhfbp_pkg::req_item_type          req_item,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output hhfbp_pkg::rsp_item_type               rsp_item,
   input  wire logic                             csr_write_enable,
   input  wire logic [hhfbp_pkg::CfgWidth-1:0]   csr_write_data
);
   import hhfbp_pkg::*;

   logic                        clearing_ff, clearing_in;
   logic [TableAddrWidth-1:0]   clear_addr_ff, clear_addr_in;
   logic [CfgWidth-1:0]         fallback_bits_ff, fallback_bits_in;

   logic                        accept;
   logic                        load_we;
   logic [LenWidth-1:0]         len_clamped;
   logic                        ram_wr_en;
   logic [TableAddrWidth-1:0]   ram_wr_addr;
   logic [TableDataWidth-1:0]   ram_wr_data;
   logic [TableDataWidth-1:0]   ram_rd_data;
   table_entry_type             rd_entry;
   table_entry_type             load_entry;
   logic                        packer_busy;
   logic                        push;
   bundle_type                  bundle;
   logic                        credit_full;

   always_comb begin
      req_stall   = clearing_ff || credit_full;
      accept      = req_valid && !req_stall;
      load_we     = accept && (req_item.opcode == OP_LOAD);
      len_clamped = (req_item.code_len > LenWidth'(MAX_CODE_LEN)) ? LenWidth'(MAX_CODE_LEN)
                                                                   : req_item.code_len;
      load_entry.code = req_item.code;
      load_entry.len  = len_clamped;
      ram_wr_en   = clearing_ff || load_we;
      ram_wr_addr = clearing_ff ? clear_addr_ff : TableAddrWidth'(req_item.symbol);
      ram_wr_data = clearing_ff ? '0 : TableDataWidth'(load_entry);
      rd_entry    = table_entry_type'(ram_rd_data);
   end

   always_comb begin
      clearing_in      = clearing_ff;
      clear_addr_in    = clear_addr_ff;
      fallback_bits_in = csr_write_enable ? csr_write_data : fallback_bits_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff      <= 1'b1;
         clear_addr_ff    <= '0;
         fallback_bits_ff <= FallbackReset;
      end else begin
         clearing_ff      <= clearing_in;
         clear_addr_ff    <= clear_addr_in;
         fallback_bits_ff <= fallback_bits_in;
      end
   end

   hhfbp_table_ram #(
      .AddrWidth (TableAddrWidth),
      .DataWidth (TableDataWidth)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (TableAddrWidth'(req_item.symbol)),
      .rd_data (ram_rd_data)
   );

   hhfbp_packer u_packer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_item       (req_item),
      .rd_entry      (rd_entry),
      .fallback_bits (fallback_bits_ff),
      .busy          (packer_busy),
      .push          (push),
      .bundle        (bundle)
   );

   hhfbp_result_queue u_result_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .bundle      (bundle),
      .in_flight   (packer_busy),
      .credit_full (credit_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule
`default_nettype wire
